// ===== rtl/utf8_byte_stream_decoder_unit_macros.svh =====
// Assertion macros shared by the UTF-8 decoder RTL.
`ifndef UTF8_BYTE_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_BYTE_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define U8D_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/utf8d_pkg.sv =====
// Types and constants for the UTF-8 byte stream decoder.
package utf8d_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned CntW   = 3;
  localparam logic [CpW-1:0] ReplChar = 21'h00FFFD;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       flush;
  } in_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           last_of_run;
  } out_t;

  // Decoder state carried between transactions.
  typedef struct packed {
    logic [2:0]     exp_len;
    logic [1:0]     held;
    logic [CpW-1:0] partial;
  } dec_state_t;

  // Result group of one transaction: cnt results, all U+FFFD but the last,
  // which carries cp.
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [CpW-1:0]  cp;
  } res_grp_t;

endpackage

// ===== rtl/utf8_byte_stream_decoder_unit.sv =====
// Top level of the UTF-8 byte stream decoder.
//
// Takes one byte (or a flush marker) per input transaction and delivers
// decoded code points, one per output transaction. ASCII passes through;
// leads 110/1110/11110 open 2/3/4-byte sequences whose 6-bit payloads are
// gathered with no overlong or surrogate checks. Bad leads and stray
// continuations give U+FFFD; a broken sequence gives U+FFFD for the lead and
// each held continuation, then the offending byte is decoded again. A flush
// turns held bytes into U+FFFD each. last_of_run marks the final result of
// each input transaction. Throughput is one byte per cycle while each byte
// causes at most one result and out_stall is low; a byte causing more than
// one result holds the input while the single output register drains one
// per cycle when out_stall is low. A byte passes an input register, then
// the decode logic feeding the result group register. The input register
// lets one more byte be taken while a finished result waits on out_stall.
module utf8_byte_stream_decoder_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  utf8d_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output utf8d_pkg::out_t out_data
);
  import utf8d_pkg::*;

  `include "utf8_byte_stream_decoder_unit_macros.svh"

  // input register
  logic       in_vld_r, in_vld_nxt;
  in_t        in_data_r;

  // decoder state
  dec_state_t st_r, st_nxt;

  // result group register: cnt results pending, last one carries cp
  logic [CntW-1:0] grp_cnt_r, grp_cnt_nxt;
  logic [CpW-1:0]  grp_cp_r, grp_cp_nxt;

  dec_state_t dec_st;
  res_grp_t   dec_grp;
  logic       out_take;
  logic       advance;

  utf8d_decode u_decode (
    .st     (st_r),
    .item   (in_data_r),
    .st_nxt (dec_st),
    .grp    (dec_grp)
  );

  assign out_valid = (grp_cnt_r != '0);
  assign out_take  = out_valid && !out_stall;
  assign out_data.code_point  = (grp_cnt_r == CntW'(1)) ? grp_cp_r : ReplChar;
  assign out_data.last_of_run = (grp_cnt_r == CntW'(1));

  // The held byte moves on once the group register is empty or its last
  // result leaves this cycle.
  assign advance  = in_vld_r &&
                    ((grp_cnt_r == '0) || ((grp_cnt_r == CntW'(1)) && out_take));
  assign in_stall = in_vld_r && !advance;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    st_nxt      = st_r;
    grp_cnt_nxt = grp_cnt_r;
    grp_cp_nxt  = grp_cp_r;
    if (!in_stall) begin
      in_vld_nxt = in_valid;
    end
    if (advance) begin
      st_nxt      = dec_st;
      grp_cnt_nxt = dec_grp.cnt;
      grp_cp_nxt  = dec_grp.cp;
    end else if (out_take) begin
      grp_cnt_nxt = grp_cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      st_r      <= '0;
      grp_cnt_r <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      st_r      <= st_nxt;
      grp_cnt_r <= grp_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_cp_r <= grp_cp_nxt;
    if (!in_stall) begin
      in_data_r <= in_data;
    end
  end

  `U8D_ASSERT_IMPL(a_grp_cnt_max, 1'b1, grp_cnt_r <= CntW'(4), "result group over four")
  `U8D_ASSERT_IMPL(a_fill_is_repl, out_valid && !out_data.last_of_run,
                   out_data.code_point == ReplChar, "non-final result not U+FFFD")
  `U8D_ASSERT_IMPL(a_seq_len, st_r.exp_len != 3'd0,
                   (st_r.exp_len >= 3'd2) && (st_r.exp_len <= 3'd4) &&
                   (({1'b0, st_r.held} + 3'd1) < st_r.exp_len),
                   "open sequence state inconsistent")
  `U8D_ASSERT_NEXT(a_drain, out_take && (grp_cnt_r > CntW'(1)),
                   grp_cnt_r == $past(grp_cnt_r) - CntW'(1), "group did not drain by one")

endmodule

// ===== rtl/utf8d_decode.sv =====
// Combinational byte decode: next decoder state and result group.
module utf8d_decode (
  input  utf8d_pkg::dec_state_t st,
  input  utf8d_pkg::in_t        item,
  output utf8d_pkg::dec_state_t st_nxt,
  output utf8d_pkg::res_grp_t   grp
);
  import utf8d_pkg::*;

  logic [7:0]     b;
  logic           f_emit;
  logic [CpW-1:0] f_cp;
  dec_state_t     f_st;
  logic [2:0]     pend_cnt;
  logic [1:0]     held_inc;
  logic           done;
  logic [CpW-1:0] ext_val;

  assign b = item.data_byte;

  // Fresh decode of a byte with no sequence open.
  always_comb begin
    f_st   = '0;
    f_emit = 1'b0;
    f_cp   = ReplChar;
    if (!b[7]) begin
      f_emit = 1'b1;
      f_cp   = {13'd0, b};
    end else if (b[7:5] == 3'b110) begin
      f_st.exp_len = 3'd2;
      f_st.partial = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      f_st.exp_len = 3'd3;
      f_st.partial = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      f_st.exp_len = 3'd4;
      f_st.partial = {18'd0, b[2:0]};
    end else begin
      f_emit = 1'b1;
    end
  end

  assign pend_cnt = (st.exp_len != 3'd0) ? ({1'b0, st.held} + 3'd1) : 3'd0;
  assign held_inc = st.held + 2'd1;
  assign done     = (({1'b0, held_inc}) + 3'd1) >= st.exp_len;
  assign ext_val  = {st.partial[CpW-7:0], b[5:0]};

  always_comb begin
    st_nxt   = st;
    grp.cnt  = '0;
    grp.cp   = ReplChar;
    if (item.flush) begin
      st_nxt  = '0;
      grp.cnt = pend_cnt;
    end else if (st.exp_len != 3'd0) begin
      if (b[7:6] == 2'b10) begin
        if (done) begin
          st_nxt  = '0;
          grp.cnt = 3'd1;
          grp.cp  = ext_val;
        end else begin
          st_nxt.held    = held_inc;
          st_nxt.partial = ext_val;
        end
      end else begin
        // broken sequence: flush what is held, then decode this byte anew
        st_nxt  = f_st;
        grp.cnt = pend_cnt + {2'd0, f_emit};
        grp.cp  = f_emit ? f_cp : ReplChar;
      end
    end else begin
      st_nxt  = f_st;
      grp.cnt = {2'd0, f_emit};
      grp.cp  = f_cp;
    end
  end

endmodule
